// File: design/tomg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tomg_pkg;

  localparam int TIME_W      = 64;
  localparam int PAYLOAD_W   = 32;
  localparam int MODULE_W    = 4;
  localparam int MOD_CMP_W   = 9;

  localparam int DEF_NUM_MODULES  = 16;
  localparam int DEF_STORE_DEPTH  = 64;
  localparam int DEF_PAYLOAD_BITS = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_SYNC   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_POP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_MOD = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MAX,
    S_SYNC_WR,
    S_MIN_GO,
    S_MIN,
    S_RESULT
  } fsm_e;

  typedef struct packed {
    logic [1:0]           mode;
    logic [MODULE_W-1:0]  module_index;
    logic [MODULE_W-1:0]  other_module;
    logic [TIME_W-1:0]    event_time;
    logic [PAYLOAD_W-1:0] event_payload;
  } tomg_in_t;

  typedef struct packed {
    logic                 release_ready;
    logic                 store_empty;
    logic [TIME_W-1:0]    horizon_time;
    logic [TIME_W-1:0]    earliest_time;
    logic                 popped_valid;
    logic [TIME_W-1:0]    popped_time;
    logic [PAYLOAD_W-1:0] popped_payload;
    logic [1:0]           status;
  } tomg_out_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } st_ctrl_t;

  typedef struct packed {
    logic clear;
    logic ins_en;
    logic sync_wr;
  } mc_ctrl_t;

  typedef struct packed {
    logic start;
    logic op_max;
  } red_ctrl_t;

endpackage

`default_nettype wire

// File: design/time_ordered_event_merger_core.sv
// Time-ordered event merger.
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per command
// (insert event, sync two modules, clear latest times, pop earliest).
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one beat
// per command, in order, with store status, horizon and any popped event.
// cfg_we_i / cfg_wdata_i write max_latency; write only while idle.
// Events sit in a row of cells kept in time order: an insert shifts the later
// cells one place right all at once, a pop shifts all cells left.
// The horizon is a min over the per-module cells, folded by a registered
// pairwise tree of L = max(1, clog2(NUM_MODULES)) levels, one level a cycle.
// Per command the FSM steps S_EXEC, then for a sync S_MAX (max fold) and
// S_SYNC_WR, then S_MIN_GO and S_MIN (min fold), then S_RESULT, which loads
// the output register once it is free.
// One command is in flight at a time; in_stall_o is low only when idle.
// A finished beat waits in the output register while the next command is
// accepted; if the receiver stalls, the following result holds in its last
// step until the register frees. Reset empties the store, zeroes latest
// times and max_latency; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module time_ordered_event_merger_core
  import tomg_pkg::*;
#(
  parameter int NUM_MODULES  = DEF_NUM_MODULES,
  parameter int STORE_DEPTH  = DEF_STORE_DEPTH,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TIME_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire tomg_in_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output tomg_out_t              out_data_o
);

  localparam int SW = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam int CW = $clog2(STORE_DEPTH + 1);

  fsm_e state_q, state_d;

  tomg_in_t          item_q;
  logic [TIME_W-1:0] max_latency_q;
  logic [CW-1:0]     count_q;
  status_e           status_q, status_c;
  logic              pop_v_q;
  logic [TIME_W-1:0] pop_time_q;
  logic [SW-1:0]     pop_pay_q;
  logic              out_valid_q;
  tomg_out_t         out_q, out_c;

  st_ctrl_t  st_ctrl;
  mc_ctrl_t  mc_ctrl;
  red_ctrl_t red_ctrl;
  logic      in_acc, out_free, load_out;
  logic      do_insert, do_pop, do_sync, do_clear;

  logic              bad_a, bad_b, full, empty;
  logic [TIME_W-1:0] cell_time [STORE_DEPTH];
  logic [SW-1:0]     cell_pay  [STORE_DEPTH];
  logic              cell_take [STORE_DEPTH];

  logic [NUM_MODULES-1:0]             hit_a, hit_b, sync_sel;
  logic [NUM_MODULES-1:0][TIME_W-1:0] latest;
  logic                               red_done;
  logic [TIME_W-1:0]                  red_result;

  assign bad_a = {{(MOD_CMP_W-MODULE_W){1'b0}}, item_q.module_index}
                 >= MOD_CMP_W'(NUM_MODULES);
  assign bad_b = {{(MOD_CMP_W-MODULE_W){1'b0}}, item_q.other_module}
                 >= MOD_CMP_W'(NUM_MODULES);
  assign full  = count_q == CW'(STORE_DEPTH);
  assign empty = count_q == '0;

  always_comb begin
    unique case (mode_e'(item_q.mode))
      MODE_INSERT: status_c = bad_a ? ST_BAD_MOD : (full ? ST_FULL : ST_OK);
      MODE_SYNC:   status_c = (bad_a || bad_b) ? ST_BAD_MOD : ST_OK;
      MODE_CLEAR:  status_c = ST_OK;
      MODE_POP:    status_c = empty ? ST_EMPTY : ST_OK;
      default:     status_c = ST_OK;
    endcase
  end

  assign do_insert = (mode_e'(item_q.mode) == MODE_INSERT) && (status_c == ST_OK);
  assign do_sync   = (mode_e'(item_q.mode) == MODE_SYNC)   && (status_c == ST_OK);
  assign do_clear  =  mode_e'(item_q.mode) == MODE_CLEAR;
  assign do_pop    = (mode_e'(item_q.mode) == MODE_POP)    && (status_c == ST_OK);

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_EXEC;
      S_EXEC:    state_d = do_sync ? S_MAX : S_MIN_GO;
      S_MAX:     if (red_done) state_d = S_SYNC_WR;
      S_SYNC_WR: state_d = S_MIN_GO;
      S_MIN_GO:  state_d = S_MIN;
      S_MIN:     if (red_done) state_d = S_RESULT;
      S_RESULT:  if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o      = 1'b1;
    st_ctrl         = '0;
    mc_ctrl         = '0;
    red_ctrl        = '0;
    load_out        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
      end
      S_EXEC: begin
        st_ctrl.insert  = do_insert;
        st_ctrl.pop     = do_pop;
        mc_ctrl.ins_en  = do_insert;
        mc_ctrl.clear   = do_clear;
        red_ctrl.start  = do_sync;
        red_ctrl.op_max = do_sync;
      end
      S_SYNC_WR: begin
        mc_ctrl.sync_wr = 1'b1;
      end
      S_MIN_GO: begin
        red_ctrl.start = 1'b1;
      end
      S_RESULT: begin
        load_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      max_latency_q <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        max_latency_q <= cfg_wdata_i;
      end
      if (st_ctrl.insert) begin
        count_q <= count_q + 1'b1;
      end else if (st_ctrl.pop) begin
        count_q <= count_q - 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
    if (state_q == S_EXEC) begin
      status_q   <= status_c;
      pop_v_q    <= do_pop;
      pop_time_q <= cell_time[0];
      pop_pay_q  <= cell_pay[0];
    end
    if (load_out) begin
      out_q <= out_c;
    end
  end

  // sorted event row
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_store
    logic              l_take;
    logic [TIME_W-1:0] l_time, r_time;
    logic [SW-1:0]     l_pay, r_pay;

    if (i == 0) begin : g_first
      assign l_take = 1'b0;
      assign l_time = '0;
      assign l_pay  = '0;
    end else begin : g_mid
      assign l_take = cell_take[i-1];
      assign l_time = cell_time[i-1];
      assign l_pay  = cell_pay[i-1];
    end
    if (i == STORE_DEPTH - 1) begin : g_last
      assign r_time = cell_time[i];
      assign r_pay  = cell_pay[i];
    end else begin : g_inner
      assign r_time = cell_time[i+1];
      assign r_pay  = cell_pay[i+1];
    end

    tomg_store_cell #(.PW(SW)) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (st_ctrl),
      .occ_i        (count_q > CW'(i)),
      .new_time_i   (item_q.event_time),
      .new_pay_i    (item_q.event_payload[SW-1:0]),
      .left_take_i  (l_take),
      .left_time_i  (l_time),
      .left_pay_i   (l_pay),
      .right_time_i (r_time),
      .right_pay_i  (r_pay),
      .take_o       (cell_take[i]),
      .time_o       (cell_time[i]),
      .pay_o        (cell_pay[i])
    );
  end

  // per-module latest times
  for (genvar j = 0; j < NUM_MODULES; j++) begin : g_mod
    assign hit_a[j] = {{(MOD_CMP_W-MODULE_W){1'b0}}, item_q.module_index}
                      == MOD_CMP_W'(j);
    assign hit_b[j] = {{(MOD_CMP_W-MODULE_W){1'b0}}, item_q.other_module}
                      == MOD_CMP_W'(j);
    assign sync_sel[j] = hit_a[j] || hit_b[j];

    tomg_module_cell u_mcell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (mc_ctrl),
      .hit_a_i  (hit_a[j]),
      .hit_b_i  (hit_b[j]),
      .time_i   (item_q.event_time),
      .mx_i     (red_result),
      .latest_o (latest[j])
    );
  end

  tomg_reduce #(.N(NUM_MODULES)) u_reduce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (red_ctrl),
    .sel_i    (sync_sel),
    .vals_i   (latest),
    .done_o   (red_done),
    .result_o (red_result)
  );

  // result beat
  always_comb begin
    logic [TIME_W-1:0] h;
    logic [TIME_W-1:0] early;
    h     = (red_result == '1) ? '0 : red_result;
    early = empty ? '0 : cell_time[0];
    out_c                = '0;
    out_c.release_ready  = !empty && (h >= max_latency_q)
                           && (early < (h - max_latency_q));
    out_c.store_empty    = empty;
    out_c.horizon_time   = h;
    out_c.earliest_time  = early;
    out_c.popped_valid   = pop_v_q;
    out_c.popped_time    = pop_v_q ? pop_time_q : '0;
    out_c.popped_payload = pop_v_q ? PAYLOAD_W'(pop_pay_q) : '0;
    out_c.status         = status_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: design/tomg_store_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tomg_store_cell
  import tomg_pkg::*;
#(
  parameter int PW = DEF_PAYLOAD_BITS
) (
  input  wire logic              clk_i,
  input  wire st_ctrl_t          ctrl_i,
  input  wire logic              occ_i,
  input  wire logic [TIME_W-1:0] new_time_i,
  input  wire logic [PW-1:0]     new_pay_i,
  input  wire logic              left_take_i,
  input  wire logic [TIME_W-1:0] left_time_i,
  input  wire logic [PW-1:0]     left_pay_i,
  input  wire logic [TIME_W-1:0] right_time_i,
  input  wire logic [PW-1:0]     right_pay_i,
  output logic                   take_o,
  output logic [TIME_W-1:0]      time_o,
  output logic [PW-1:0]          pay_o
);

  logic [TIME_W-1:0] time_q;
  logic [PW-1:0]     pay_q;

  // empty, or holds a later time: new beat lands here or left of here
  assign take_o = !occ_i || (time_q > new_time_i);
  assign time_o = time_q;
  assign pay_o  = pay_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      if (left_take_i) begin
        time_q <= left_time_i;
        pay_q  <= left_pay_i;
      end else if (take_o) begin
        time_q <= new_time_i;
        pay_q  <= new_pay_i;
      end
    end else if (ctrl_i.pop) begin
      time_q <= right_time_i;
      pay_q  <= right_pay_i;
    end
  end

endmodule

`default_nettype wire

// File: design/tomg_module_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tomg_module_cell
  import tomg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mc_ctrl_t          ctrl_i,
  input  wire logic              hit_a_i,
  input  wire logic              hit_b_i,
  input  wire logic [TIME_W-1:0] time_i,
  input  wire logic [TIME_W-1:0] mx_i,
  output logic [TIME_W-1:0]      latest_o
);

  logic [TIME_W-1:0] latest_q, latest_d;

  always_comb begin
    latest_d = latest_q;
    if (ctrl_i.clear) begin
      latest_d = '0;
    end else if (ctrl_i.ins_en && hit_a_i && (time_i > latest_q)) begin
      latest_d = time_i;
    end else if (ctrl_i.sync_wr && (hit_a_i || hit_b_i)) begin
      latest_d = mx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q <= '0;
    end else begin
      latest_q <= latest_d;
    end
  end

  assign latest_o = latest_q;

endmodule

`default_nettype wire

// File: design/tomg_reduce.sv
`timescale 1ns / 1ps
`default_nettype none

module tomg_reduce
  import tomg_pkg::*;
#(
  parameter int N = DEF_NUM_MODULES
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire red_ctrl_t                ctrl_i,
  input  wire logic [N-1:0]             sel_i,
  input  wire logic [N-1:0][TIME_W-1:0] vals_i,
  output logic                          done_o,
  output logic [TIME_W-1:0]             result_o
);

  localparam int LV  = (N > 1) ? $clog2(N) : 1;
  localparam int P   = 1 << LV;
  localparam int LVW = $clog2(LV + 1);

  logic [TIME_W-1:0] red_q [P];
  logic [TIME_W-1:0] ld    [P];
  logic              busy_q, done_q, op_max_q;
  logic [LVW-1:0]    lvl_q;

  for (genvar j = 0; j < P; j++) begin : g_ld
    if (j < N) begin : g_real
      assign ld[j] = ctrl_i.op_max ? (sel_i[j] ? vals_i[j] : '0) : vals_i[j];
    end else begin : g_pad
      assign ld[j] = ctrl_i.op_max ? '0 : '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      for (int j = 0; j < P; j++) begin
        red_q[j] <= ld[j];
      end
    end else if (busy_q) begin
      for (int j = 0; j < P / 2; j++) begin
        if (op_max_q) begin
          red_q[j] <= (red_q[2*j] > red_q[2*j+1]) ? red_q[2*j] : red_q[2*j+1];
        end else begin
          red_q[j] <= (red_q[2*j] < red_q[2*j+1]) ? red_q[2*j] : red_q[2*j+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      op_max_q <= 1'b0;
      lvl_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q   <= 1'b1;
        op_max_q <= ctrl_i.op_max;
        lvl_q    <= '0;
      end else if (busy_q) begin
        lvl_q <= lvl_q + 1'b1;
        if (lvl_q == LVW'(LV - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = red_q[0];

endmodule

`default_nettype wire

// File: design/tomg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tomg_checker
  import tomg_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire tomg_out_t         out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // one command in flight: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o)
    else $error("input taken while a command is in flight");

  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.popped_valid) |->
      (out_data_o.status == ST_OK))
    else $error("popped beat with error status");

  a_no_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.popped_valid) |->
      (out_data_o.popped_time == '0 && out_data_o.popped_payload == '0))
    else $error("popped fields nonzero without a pop");

  a_empty_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.store_empty) |->
      (out_data_o.earliest_time == '0 && !out_data_o.release_ready))
    else $error("empty store reports an event");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output beat changed");

endmodule

bind time_ordered_event_merger_core tomg_checker u_tomg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
